// File: hdl/brq_pkg.sv
// ----------------------------------------------------------------------------
// brq_pkg: byte ring queue shared definitions
// Widths, limits, codes and the types shared by the byte ring queue modules.
// ----------------------------------------------------------------------------
package brq_pkg;

	localparam int DEPTH        = 256;
	localparam int MAX_TRANSFER = 8;
	localparam int ADDR_W       = $clog2(DEPTH);
	localparam int CAP_W        = ADDR_W + 1;
	localparam int CNT_W        = 4;
	localparam int STEP_W       = 3;
	localparam int DATA_W       = 64;

	typedef enum logic [1:0] {
		OP_PUSH  = 2'd0,
		OP_POP   = 2'd1,
		OP_CHECK = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_INVALID = 2'd1,
		ST_SHORT   = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_CHECK,
		S_XFER,
		S_DRAIN
	} state_t;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] addr;
		logic [7:0]        wdata;
	} ram_req_t;

	typedef struct packed {
		logic             clear;
		logic [CAP_W-1:0] cap;
	} cfg_t;

endpackage

// File: hdl/brq_ram.sv
// ----------------------------------------------------------------------------
// brq_ram: byte store
// Single-port byte memory, one access per cycle, registered read data.
// ----------------------------------------------------------------------------
module brq_ram (
	input  logic              clk,
	input  brq_pkg::ram_req_t req,
	output logic [7:0]        rdata
);

	logic [7:0] mem [brq_pkg::DEPTH];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.addr] <= req.wdata;
		end
		rdata <= mem[req.addr];
	end

endmodule

// File: hdl/brq_seq.sv
// ----------------------------------------------------------------------------
// brq_seq: byte ring queue sequencer
// Checks each item, then moves its bytes one per cycle through the store,
// stepping the ring indices with one shared wrap-around incrementer.
// ----------------------------------------------------------------------------
module brq_seq (
	input  logic                          clk,
	input  logic                          arst_n,
	input  brq_pkg::cfg_t                 cfg,
	input  logic                          start,
	input  logic [1:0]                    operation,
	input  logic [brq_pkg::CNT_W-1:0]     byte_count,
	input  logic [brq_pkg::DATA_W-1:0]    push_bytes,
	input  logic [7:0]                    rdata,
	output brq_pkg::ram_req_t             req,
	output logic                          busy,
	output logic                          done,
	output logic [1:0]                    status,
	output logic [brq_pkg::DATA_W-1:0]    pop_bytes,
	output logic [brq_pkg::CAP_W-1:0]     fill_level
);

	brq_pkg::state_t                  state_q, state_d;
	logic [1:0]                       op_q;
	logic [brq_pkg::CNT_W-1:0]        cnt_q;
	logic [brq_pkg::DATA_W-1:0]       data_q;
	logic [brq_pkg::DATA_W-1:0]       acc_q;
	logic [brq_pkg::ADDR_W-1:0]       rd_idx_q, wr_idx_q;
	logic [brq_pkg::CAP_W-1:0]        fill_q;
	logic [brq_pkg::STEP_W-1:0]       step_q, rd_pos_q;
	logic                             rd_valid_q;
	logic                             done_q;
	brq_pkg::status_t                 status_q, status_d;

	logic                             is_push, is_pop, op_ok;
	logic [brq_pkg::ADDR_W-1:0]       cur_idx, nxt_idx;
	logic [brq_pkg::CAP_W-1:0]        inc_idx, free_room;
	logic                             last_step;

	assign is_push = (op_q == brq_pkg::OP_PUSH);
	assign is_pop  = (op_q == brq_pkg::OP_POP);

	always_comb begin
		case (op_q)
			brq_pkg::OP_PUSH, brq_pkg::OP_POP, brq_pkg::OP_CHECK: op_ok = 1'b1;
			default: op_ok = 1'b0;
		endcase
	end

	// shared index unit: one step forward, wrap at capacity
	assign cur_idx = is_push ? wr_idx_q : rd_idx_q;
	assign inc_idx = {1'b0, cur_idx} + brq_pkg::CAP_W'(1);
	assign nxt_idx = (inc_idx >= cfg.cap) ? '0 : inc_idx[brq_pkg::ADDR_W-1:0];

	assign free_room = cfg.cap - fill_q;
	assign last_step = ({1'b0, step_q} == (cnt_q - brq_pkg::CNT_W'(1)));

	always_comb begin
		status_d = brq_pkg::ST_OK;
		if (cnt_q == '0 || cnt_q > brq_pkg::CNT_W'(brq_pkg::MAX_TRANSFER) || !op_ok) begin
			status_d = brq_pkg::ST_INVALID;
		end else if (is_push) begin
			if (free_room < brq_pkg::CAP_W'(cnt_q)) status_d = brq_pkg::ST_SHORT;
		end else begin
			if (fill_q < brq_pkg::CAP_W'(cnt_q)) status_d = brq_pkg::ST_SHORT;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			brq_pkg::S_IDLE: begin
				if (start) state_d = brq_pkg::S_CHECK;
			end
			brq_pkg::S_CHECK: begin
				if (status_d == brq_pkg::ST_OK && (is_push || is_pop))
					state_d = brq_pkg::S_XFER;
				else
					state_d = brq_pkg::S_IDLE;
			end
			brq_pkg::S_XFER: begin
				if (last_step) state_d = brq_pkg::S_DRAIN;
			end
			brq_pkg::S_DRAIN: state_d = brq_pkg::S_IDLE;
			default: state_d = brq_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		req.we    = (state_q == brq_pkg::S_XFER) && is_push;
		req.addr  = cur_idx;
		req.wdata = data_q[{step_q, 3'b000} +: 8];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= brq_pkg::S_IDLE;
			rd_idx_q   <= '0;
			wr_idx_q   <= '0;
			fill_q     <= '0;
			step_q     <= '0;
			rd_valid_q <= 1'b0;
			done_q     <= 1'b0;
			status_q   <= brq_pkg::ST_OK;
		end else begin
			state_q    <= state_d;
			done_q     <= 1'b0;
			rd_valid_q <= 1'b0;
			if (cfg.clear) begin
				rd_idx_q <= '0;
				wr_idx_q <= '0;
				fill_q   <= '0;
			end
			case (state_q)
				brq_pkg::S_IDLE: begin
					step_q <= '0;
				end
				brq_pkg::S_CHECK: begin
					status_q <= status_d;
					if (state_d == brq_pkg::S_IDLE) done_q <= 1'b1;
				end
				brq_pkg::S_XFER: begin
					step_q <= step_q + brq_pkg::STEP_W'(1);
					if (is_push) begin
						wr_idx_q <= nxt_idx;
						fill_q   <= fill_q + brq_pkg::CAP_W'(1);
					end else begin
						rd_idx_q   <= nxt_idx;
						fill_q     <= fill_q - brq_pkg::CAP_W'(1);
						rd_valid_q <= 1'b1;
					end
				end
				brq_pkg::S_DRAIN: begin
					done_q <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		rd_pos_q <= step_q;
		if (state_q == brq_pkg::S_IDLE && start) begin
			op_q   <= operation;
			cnt_q  <= byte_count;
			data_q <= push_bytes;
			acc_q  <= '0;
		end else if (rd_valid_q) begin
			acc_q[{rd_pos_q, 3'b000} +: 8] <= rdata;
		end
	end

	assign busy       = (state_q != brq_pkg::S_IDLE);
	assign done       = done_q;
	assign status     = status_q;
	assign pop_bytes  = acc_q;
	assign fill_level = fill_q;

	a_fill_le_cap: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= cfg.cap)
		else $error("fill level above capacity");

	a_rd_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, rd_idx_q} < cfg.cap)
		else $error("read index beyond capacity");

	a_wr_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, wr_idx_q} < cfg.cap)
		else $error("write index beyond capacity");

	a_done_origin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(done_q) |-> ($past(state_q) == brq_pkg::S_CHECK ||
			$past(state_q) == brq_pkg::S_DRAIN))
		else $error("result strobe without finished item");

	a_fail_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && status_q != brq_pkg::ST_OK) |-> (acc_q == '0))
		else $error("pop data on failed item");

endmodule

// File: hdl/byte_ring_queue_multi_transfer_top.sv
// ----------------------------------------------------------------------------
// byte_ring_queue_multi_transfer_top: byte ring queue, multi-byte transfers
// Circular byte queue with configurable capacity and all-or-nothing
// push, pop and check items of 1 to 8 bytes.
//
// Usage:
//   An item is taken when start is high and busy is low. Its result beat
//   (status, pop_bytes, fill_level) shows for one cycle with done high;
//   the receiver cannot stall it.
//   A transfer passes a check state, a transfer state that moves its bytes
//   one per cycle through the single-port store, and a drain state for the
//   last read to land, then raises done; an invalid, refused or check item
//   raises done from the check state, in the cycle after it is taken. No new
//   item is taken until done rises, as busy stays high until then.
//   cfg_write/cfg_data set the capacity (0 taken as 1, above 256 taken
//   as 256) and empty the queue; write it only while busy is low.
//   Reset empties the queue and sets capacity to 256; store contents are
//   left as they are and are never read before being written.
// ----------------------------------------------------------------------------
module byte_ring_queue_multi_transfer_top (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_write,
	input  logic [brq_pkg::CAP_W-1:0]  cfg_data,
	input  logic                       start,
	output logic                       busy,
	input  logic [1:0]                 operation,
	input  logic [brq_pkg::CNT_W-1:0]  byte_count,
	input  logic [brq_pkg::DATA_W-1:0] push_bytes,
	output logic                       done,
	output logic [1:0]                 status,
	output logic [brq_pkg::DATA_W-1:0] pop_bytes,
	output logic [brq_pkg::CAP_W-1:0]  fill_level
);

	logic [brq_pkg::CAP_W-1:0] cap_q, cap_d;
	brq_pkg::cfg_t             cfg;
	brq_pkg::ram_req_t         req;
	logic [7:0]                rdata;

	// clamp to 1..DEPTH
	always_comb begin
		cap_d = cfg_data;
		if (cfg_data == '0)
			cap_d = brq_pkg::CAP_W'(1);
		else if (cfg_data > brq_pkg::CAP_W'(brq_pkg::DEPTH))
			cap_d = brq_pkg::CAP_W'(brq_pkg::DEPTH);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= brq_pkg::CAP_W'(brq_pkg::DEPTH);
		end else if (cfg_write) begin
			cap_q <= cap_d;
		end
	end

	assign cfg.clear = cfg_write;
	assign cfg.cap   = cap_q;

	brq_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.start      (start),
		.operation  (operation),
		.byte_count (byte_count),
		.push_bytes (push_bytes),
		.rdata      (rdata),
		.req        (req),
		.busy       (busy),
		.done       (done),
		.status     (status),
		.pop_bytes  (pop_bytes),
		.fill_level (fill_level)
	);

	brq_ram u_ram (
		.clk   (clk),
		.req   (req),
		.rdata (rdata)
	);

endmodule

// File: dv/brq_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brq_checker: byte ring queue result checker
// Watches the item, configuration and result channels of the byte ring
// queue. It keeps its own copy of the queue, works out the expected beat
// for each accepted item, and compares each result beat field by field.
// ----------------------------------------------------------------------------
module brq_checker
	import brq_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_write,
	input  logic [CAP_W-1:0]  cfg_data,
	input  logic              start,
	input  logic              busy,
	input  logic [1:0]        operation,
	input  logic [CNT_W-1:0]  byte_count,
	input  logic [DATA_W-1:0] push_bytes,
	input  logic              done,
	input  logic [1:0]        status,
	input  logic [DATA_W-1:0] pop_bytes,
	input  logic [CAP_W-1:0]  fill_level,
	output int                pending,
	output int                fail_count,
	output int                n_ok,
	output int                n_short,
	output int                n_bad,
	output int                peak_fill,
	output int                full_hits
);

	typedef struct packed {
		status_t           st;
		logic [DATA_W-1:0] bytes;
		logic [CAP_W-1:0]  level;
	} ring_result_t;

	logic [7:0]        ring_mem [DEPTH];
	logic [ADDR_W-1:0] rd_ptr;
	logic [ADDR_W-1:0] wr_ptr;
	logic [CAP_W-1:0]  level;
	logic [CAP_W-1:0]  cap;
	ring_result_t      expected_beats [$];
	ring_result_t      want;
	int                n_fail = 0;
	int                n_seen = 0;

	assign fail_count = n_fail;

	task automatic report(input string field, input logic [DATA_W-1:0] got,
			input logic [DATA_W-1:0] exp_val);
		n_fail++;
		if (n_fail <= 30)
			$display("brq_checker: %s mismatch on result %0d at %0t: got %h, expected %h",
				field, n_seen, $realtime, got, exp_val);
	endtask

	function automatic logic [ADDR_W-1:0] next_slot(input logic [ADDR_W-1:0] ptr);
		if (CAP_W'(ptr) + CAP_W'(1) >= cap)
			return '0;
		return ptr + 1'b1;
	endfunction

	function automatic ring_result_t apply_transfer(input logic [1:0] op,
			input logic [CNT_W-1:0] cnt, input logic [DATA_W-1:0] data);
		ring_result_t r;
		int           i;
		r.st    = ST_OK;
		r.bytes = '0;
		if (cnt == 0 || cnt > MAX_TRANSFER || op > OP_CHECK) begin
			r.st = ST_INVALID;
		end else if (op == OP_PUSH) begin
			if (cap - level < CAP_W'(cnt)) begin
				r.st = ST_SHORT;
			end else begin
				for (i = 0; i < cnt; i++) begin
					ring_mem[wr_ptr] = data[8*i +: 8];
					wr_ptr = next_slot(wr_ptr);
					level++;
				end
				if (level == cap)
					full_hits++;
			end
		end else if (op == OP_POP) begin
			if (level < CAP_W'(cnt)) begin
				r.st = ST_SHORT;
			end else begin
				for (i = 0; i < cnt; i++) begin
					r.bytes[8*i +: 8] = ring_mem[rd_ptr];
					rd_ptr = next_slot(rd_ptr);
					level--;
				end
			end
		end else if (level < CAP_W'(cnt)) begin
			r.st = ST_SHORT;
		end
		r.level = level;
		if (int'(level) > peak_fill)
			peak_fill = int'(level);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_beats.delete();
			rd_ptr    = '0;
			wr_ptr    = '0;
			level     = '0;
			cap       = CAP_W'(DEPTH);
			n_ok      = 0;
			n_short   = 0;
			n_bad     = 0;
			peak_fill = 0;
			full_hits = 0;
			pending <= 0;
		end else begin
			if (done) begin
				n_seen++;
				if (expected_beats.size() == 0) begin
					report("unexpected beat", {62'd0, status}, '0);
				end else begin
					want = expected_beats.pop_front();
					if (status !== want.st)
						report("status", {62'd0, status}, {62'd0, want.st});
					if (pop_bytes !== want.bytes)
						report("pop_bytes", pop_bytes, want.bytes);
					if (fill_level !== want.level)
						report("fill_level", {55'd0, fill_level}, {55'd0, want.level});
					case (want.st)
						ST_OK:    n_ok++;
						ST_SHORT: n_short++;
						default:  n_bad++;
					endcase
				end
			end
			if (start && !busy)
				expected_beats.push_back(apply_transfer(operation, byte_count, push_bytes));
			if (cfg_write) begin
				if (cfg_data == 0)
					cap = CAP_W'(1);
				else if (cfg_data > CAP_W'(DEPTH))
					cap = CAP_W'(DEPTH);
				else
					cap = cfg_data;
				rd_ptr = '0;
				wr_ptr = '0;
				level  = '0;
			end
			pending <= expected_beats.size();
		end
	end

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: byte ring queue testbench
// Drives directed and random push, pop and check beats through several
// capacity settings, with random gaps on the item side, and gives the
// verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module tb_top;

	import brq_pkg::*;

	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int         STALL_LIMIT = 3000;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              cfg_write;
	logic [CAP_W-1:0]  cfg_data;
	logic              start;
	logic              busy;
	logic [1:0]        operation;
	logic [CNT_W-1:0]  byte_count;
	logic [DATA_W-1:0] push_bytes;
	logic              done;
	logic [1:0]        status;
	logic [DATA_W-1:0] pop_bytes;
	logic [CAP_W-1:0]  fill_level;

	int pending;
	int fail_count;
	int n_ok;
	int n_short;
	int n_bad;
	int peak_fill;
	int full_hits;
	int n_sent = 0;
	int n_settings = 0;
	int cur_cap = DEPTH;
	int quiet_cycles = 0;

	always #5 clk = ~clk;

	byte_ring_queue_multi_transfer_top dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_write  (cfg_write),
		.cfg_data   (cfg_data),
		.start      (start),
		.busy       (busy),
		.operation  (operation),
		.byte_count (byte_count),
		.push_bytes (push_bytes),
		.done       (done),
		.status     (status),
		.pop_bytes  (pop_bytes),
		.fill_level (fill_level)
	);

	brq_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_write  (cfg_write),
		.cfg_data   (cfg_data),
		.start      (start),
		.busy       (busy),
		.operation  (operation),
		.byte_count (byte_count),
		.push_bytes (push_bytes),
		.done       (done),
		.status     (status),
		.pop_bytes  (pop_bytes),
		.fill_level (fill_level),
		.pending    (pending),
		.fail_count (fail_count),
		.n_ok       (n_ok),
		.n_short    (n_short),
		.n_bad      (n_bad),
		.peak_fill  (peak_fill),
		.full_hits  (full_hits)
	);

	// watchdog: cycles with no beat, item or register write
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done || cfg_write) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("tb_top: stalled for %0d cycles", quiet_cycles);
			$display("tb_top: FAIL");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic send(input logic [1:0] op, input logic [CNT_W-1:0] cnt,
			input logic [DATA_W-1:0] data);
		start      <= 1'b1;
		operation  <= op;
		byte_count <= cnt;
		push_bytes <= data;
		do @(posedge clk); while (busy);
		n_sent++;
	endtask

	task automatic idle(input int cycles);
		start      <= 1'b0;
		operation  <= 2'($urandom);
		byte_count <= CNT_W'($urandom);
		push_bytes <= {$urandom, $urandom};
		cfg_data   <= CAP_W'($urandom);
		repeat (cycles) @(posedge clk);
	endtask

	task automatic settle();
		start <= 1'b0;
		do @(posedge clk); while (pending != 0);
		while (busy) @(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic set_capacity(input logic [CAP_W-1:0] value);
		settle();
		cfg_write <= 1'b1;
		cfg_data  <= value;
		@(posedge clk);
		cfg_write <= 1'b0;
		repeat (2) @(posedge clk);
		if (value == 0)
			cur_cap = 1;
		else if (value > DEPTH)
			cur_cap = DEPTH;
		else
			cur_cap = int'(value);
		n_settings++;
	endtask

	task automatic random_item(input int push_pct);
		int               r;
		int               hi;
		logic [1:0]       op;
		logic [CNT_W-1:0] cnt;
		r = $urandom_range(99);
		if (r < 8) begin
			op  = 2'($urandom);
			cnt = $urandom_range(1) ? CNT_W'(0) : CNT_W'($urandom_range(9, 15));
			if (op == OP_UNUSED)
				cnt = CNT_W'($urandom);
		end else begin
			r = $urandom_range(99);
			if (r < push_pct)
				op = OP_PUSH;
			else if (r < push_pct + (100 - push_pct) * 3 / 4)
				op = OP_POP;
			else
				op = OP_CHECK;
			hi  = (cur_cap < MAX_TRANSFER && $urandom_range(1)) ? cur_cap + 1 : MAX_TRANSFER;
			cnt = CNT_W'($urandom_range(1, hi));
		end
		send(op, cnt, {$urandom, $urandom});
	endtask

	initial begin
		int caps [12];
		int p;
		int k;
		int items;
		int cap_val;
		bit quiet;

		caps = '{17, 1, 511, 2, 9, 0, 256, 300, -1, 3, 64, 8};
		arst_n     = 1'b0;
		cfg_write  = 1'b0;
		cfg_data   = '0;
		start      = 1'b0;
		operation  = '0;
		byte_count = '0;
		push_bytes = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty queue, bad counts and codes, ignored upper bytes
		send(OP_CHECK, 4'd1, '0);
		send(OP_POP, 4'd1, '0);
		send(OP_PUSH, 4'd0, '1);
		send(OP_PUSH, 4'd9, '1);
		send(OP_POP, 4'd15, '0);
		send(OP_UNUSED, 4'd4, '1);
		send(OP_PUSH, 4'd8, '1);
		send(OP_PUSH, 4'd1, 64'hFFFF_FFFF_FFFF_FF00);
		send(OP_PUSH, 4'd3, 64'hA5A5_A5A5_A512_3456);
		send(OP_CHECK, 4'd12, '0);
		send(OP_CHECK, 4'd8, '0);
		send(OP_POP, 4'd8, '1);
		send(OP_CHECK, 4'd5, '0);
		send(OP_POP, 4'd4, '0);

		// single-byte store, then wrap in a two-byte store
		set_capacity('0);
		send(OP_PUSH, 4'd1, 64'h0000_0000_0000_005A);
		send(OP_PUSH, 4'd1, '1);
		send(OP_CHECK, 4'd1, '0);
		send(OP_POP, 4'd1, '0);
		send(OP_POP, 4'd1, '0);
		set_capacity(CAP_W'(2));
		send(OP_PUSH, 4'd2, 64'h0000_0000_0000_C3B2);
		send(OP_PUSH, 4'd1, '1);
		send(OP_POP, 4'd1, '0);
		send(OP_PUSH, 4'd1, 64'h0000_0000_0000_0081);
		send(OP_POP, 4'd2, '0);

		for (p = 0; p < 12; p++) begin
			cap_val = (caps[p] < 0) ? $urandom_range(1, DEPTH) : caps[p];
			set_capacity(CAP_W'(cap_val));
			items = (cur_cap > 64) ? 150 : 70;
			quiet = (p == 11) || (p % 3 == 1);
			for (k = 0; k < items; k++) begin
				random_item((k < items * 2 / 3) ? 85 : 25);
				if (!quiet && $urandom_range(99) < 30)
					idle($urandom_range(1, 9));
			end
		end

		start <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (20) @(posedge clk);
		$display("tb_top: %0d items over %0d capacity settings: %0d done, %0d refused, %0d invalid",
			n_sent, n_settings, n_ok, n_short, n_bad);
		$display("tb_top: peak fill %0d bytes, queue pushed to full %0d times",
			peak_fill, full_hits);
		if (fail_count == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

endmodule

// File: byte_ring_queue_multi_transfer_top.f
hdl/brq_pkg.sv
hdl/brq_ram.sv
hdl/brq_seq.sv
hdl/byte_ring_queue_multi_transfer_top.sv
dv/brq_checker.sv
dv/tb_top.sv
